// ===== rtl/tlik_pkg.sv =====
// shared types, constants and the arctangent table for the two-link arm solver
`default_nettype none
package tlik_pkg;
	localparam int X_W = 20;
	localparam int LEN_W = 19;
	localparam int ANG_OUT_W = 16;
	localparam int ANG_W = 28;
	localparam int XY_W = 32;
	localparam int CW = 34;
	localparam int RAD_W = 60;
	localparam int ROOT_W = 30;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam logic [LEN_W-1:0] LEN_RESET = 19'd1024;

	localparam logic CFG_UPPER = 1'b0;
	localparam logic CFG_LOWER = 1'b1;

	localparam logic signed [ANG_W-1:0] ANG_PI = 28'sd52707179;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 28'sd26353589;
	localparam logic signed [ANG_W-1:0] ANG_THREE_HALF_PI = 28'sd79060768;

	typedef struct packed {
		logic signed [X_W-1:0] hand_x;
		logic signed [X_W-1:0] hand_z;
	} in_t;

	typedef struct packed {
		logic                        reachable;
		logic signed [ANG_OUT_W-1:0] shoulder_angle;
		logic signed [ANG_OUT_W-1:0] elbow_angle;
	} out_t;

	// atan(2^-i) in q.24 radians, rounded
	function automatic logic signed [ANG_W-1:0] atan_tab(input int i);
		case (i)
			0: return 28'sd13176795;
			1: return 28'sd7778716;
			2: return 28'sd4110060;
			3: return 28'sd2086331;
			4: return 28'sd1047214;
			5: return 28'sd524117;
			6: return 28'sd262123;
			7: return 28'sd131069;
			8: return 28'sd65536;
			9: return 28'sd32768;
			10: return 28'sd16384;
			11: return 28'sd8192;
			12: return 28'sd4096;
			13: return 28'sd2048;
			14: return 28'sd1024;
			15: return 28'sd512;
			16: return 28'sd256;
			17: return 28'sd128;
			18: return 28'sd64;
			19: return 28'sd32;
			20: return 28'sd16;
			21: return 28'sd8;
			22: return 28'sd4;
			23: return 28'sd2;
			24: return 28'sd1;
			default: return '0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== rtl/tlik_sqrt.sv =====
// pipelined integer square root, one result bit per stage, several lanes in lockstep
`default_nettype none
module tlik_sqrt #(
	parameter int LANES = 1,
	parameter int SIDE_W = 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  up_valid,
	input  logic [LANES-1:0][tlik_pkg::RAD_W-1:0]  up_rad,
	input  logic [SIDE_W-1:0]                     up_side,
	output logic                                  dn_valid,
	output logic [LANES-1:0][tlik_pkg::ROOT_W-1:0] dn_root,
	output logic [SIDE_W-1:0]                     dn_side
);
	import tlik_pkg::*;

	localparam int N = ROOT_W;
	localparam int RW = RAD_W + 1;

	logic [N-1:0]                vld_s;
	logic [LANES-1:0][RW-1:0]    rem_s [N];
	logic [LANES-1:0][RW-1:0]    res_s [N];
	logic [SIDE_W-1:0]           side_s [N];
	logic [LANES-1:0][RW-1:0]    rem_i [N];
	logic [LANES-1:0][RW-1:0]    res_i [N];
	logic [SIDE_W-1:0]           side_i [N];

	function automatic logic [2*RW-1:0] sqrt_step(input logic [RW-1:0] rem,
			input logic [RW-1:0] res, input int k);
		logic [RW-1:0] bitc;
		logic [RW-1:0] t;
		logic [RW-1:0] rem_n;
		logic [RW-1:0] res_n;
		bitc = RW'(1) << (2 * (N - 1 - k));
		t = res + bitc;
		if (rem >= t) begin
			rem_n = rem - t;
			res_n = (res >> 1) + bitc;
		end else begin
			rem_n = rem;
			res_n = res >> 1;
		end
		return {rem_n, res_n};
	endfunction

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem_i[0][l] = {1'b0, up_rad[l]};
			res_i[0][l] = '0;
		end
		side_i[0] = up_side;
		for (int k = 1; k < N; k++) begin
			rem_i[k] = rem_s[k-1];
			res_i[k] = res_s[k-1];
			side_i[k] = side_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], up_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				for (int l = 0; l < LANES; l++) begin
					{rem_s[k][l], res_s[k][l]} <= sqrt_step(rem_i[k][l], res_i[k][l], k);
				end
				side_s[k] <= side_i[k];
			end
		end
	end

	assign dn_valid = vld_s[N-1];
	assign dn_side = side_s[N-1];
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			dn_root[l] = res_s[N-1][l][N-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/tlik_cordic.sv =====
// pipelined cordic vectoring atan2: half-plane fold, normalize, then one rotation per stage
`default_nettype none
module tlik_cordic #(
	parameter int LANES = 1,
	parameter int SIDE_W = 1,
	parameter int STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 up_valid,
	input  logic [LANES-1:0][tlik_pkg::XY_W-1:0]  up_x,
	input  logic [LANES-1:0][tlik_pkg::XY_W-1:0]  up_y,
	input  logic [SIDE_W-1:0]                    up_side,
	output logic                                 dn_valid,
	output logic [LANES-1:0][tlik_pkg::ANG_W-1:0] dn_ang,
	output logic [SIDE_W-1:0]                    dn_side
);
	import tlik_pkg::*;

	localparam int NORM = 5;
	localparam int NORM_LIM = 30;
	localparam int S = 1 + NORM + STEPS;

	typedef struct packed {
		logic signed [CW-1:0]    x;
		logic signed [CW-1:0]    y;
		logic signed [ANG_W-1:0] ang;
		logic [CW-1:0]           m;
		logic                    zero;
	} cst_t;

	logic [S-1:0]      vld_s;
	cst_t              st_s [S][LANES];
	cst_t              st_i [S][LANES];
	logic [SIDE_W-1:0] side_s [S];
	logic [SIDE_W-1:0] side_i [S];

	function automatic cst_t cstep(input cst_t s, input int k);
		cst_t r;
		int a;
		int i;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		r = s;
		a = 0;
		i = 0;
		if (k == 0) begin
			if (s.x < 0) begin
				r.ang = (s.y >= 0) ? ANG_PI : -ANG_PI;
				r.x = -s.x;
				r.y = -s.y;
			end
			ax = (r.x < 0) ? -r.x : r.x;
			ay = (r.y < 0) ? -r.y : r.y;
			r.m = (ax > ay) ? ax : ay;
			r.zero = (r.m == '0);
		end else if (k <= NORM) begin
			a = 1 << (NORM - k);
			if (s.m < (CW'(1) << (NORM_LIM - a))) begin
				r.x = s.x <<< a;
				r.y = s.y <<< a;
				r.m = s.m << a;
			end
		end else begin
			i = k - NORM - 1;
			xs = s.x >>> i;
			ys = s.y >>> i;
			if (s.y >= 0) begin
				r.x = s.x + ys;
				r.y = s.y - xs;
				r.ang = s.ang + atan_tab(i);
			end else begin
				r.x = s.x - ys;
				r.y = s.y + xs;
				r.ang = s.ang - atan_tab(i);
			end
		end
		return r;
	endfunction

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			st_i[0][l].x = {{(CW-XY_W){up_x[l][XY_W-1]}}, up_x[l]};
			st_i[0][l].y = {{(CW-XY_W){up_y[l][XY_W-1]}}, up_y[l]};
			st_i[0][l].ang = '0;
			st_i[0][l].m = '0;
			st_i[0][l].zero = 1'b0;
		end
		side_i[0] = up_side;
		for (int k = 1; k < S; k++) begin
			st_i[k] = st_s[k-1];
			side_i[k] = side_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[S-2:0], up_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < S; k++) begin
				for (int l = 0; l < LANES; l++) begin
					st_s[k][l] <= cstep(st_i[k][l], k);
				end
				side_s[k] <= side_i[k];
			end
		end
	end

	assign dn_valid = vld_s[S-1];
	assign dn_side = side_s[S-1];
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			dn_ang[l] = st_s[S-1][l].zero ? '0 : st_s[S-1][l].ang;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/two_link_arm_inverse_kinematics.sv =====
// two-link planar arm inverse kinematics, fully pipelined top level
// throughput: one beat per cycle while the result beat is not stalled
// the main stages are the two 30-stage square roots and the cordic
// a stalled result beat freezes the whole pipeline; in_stall follows out_stall then
// arst_n clears all valid bits and sets both link lengths to 1024
`default_nettype none
module two_link_arm_inverse_kinematics #(
	parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  tlik_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output tlik_pkg::out_t             out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [tlik_pkg::LEN_W-1:0] cfg_data
);
	import tlik_pkg::*;

	typedef struct packed {
		logic                  bad;
		logic signed [X_W-1:0] x;
		logic signed [21:0]    z;
	} side_c_t;

	typedef struct packed {
		side_c_t            c;
		logic signed [43:0] ea;
		logic signed [43:0] sa;
		logic [39:0]        eb;
	} side_a_t;

	typedef struct packed {
		side_c_t            c;
		logic signed [30:0] a0;
		logic signed [30:0] a1;
	} side_b_t;

	logic [LEN_W-1:0] e_q;
	logic [LEN_W-1:0] f_q;
	logic             adv;

	// configuration
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= LEN_RESET;
			f_q <= LEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_UPPER: e_q <= cfg_data;
				CFG_LOWER: f_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front stages
	logic                  v_s1, v_s2, v_s3, v_s4;
	logic signed [X_W-1:0] x_s1, x_s2, x_s3;
	logic signed [21:0]    z_s1, z_s2, z_s3;
	logic [41:0]           xx_s2, zz_s2;
	logic [37:0]           ee_s2, ff_s2, ef_s2, ee_s3, ff_s3, ef_s3;
	logic [39:0]           sum2_s2, sum2_s3;
	logic                  zl_s2, zl_s3;
	logic [42:0]           l2_s3;
	side_a_t               sa_s4;
	logic [RAD_W-1:0]      rad_s4;

	logic [19:0]        len_sum;
	logic signed [39:0] xsq;
	logic signed [43:0] zsq;
	logic [37:0]        ee_n, ff_n, ef_n;
	logic [39:0]        sum2_n;

	assign len_sum = {1'b0, e_q} + {1'b0, f_q};
	assign xsq = x_s1 * x_s1;
	assign zsq = z_s1 * z_s1;
	assign ee_n = e_q * e_q;
	assign ff_n = f_q * f_q;
	assign ef_n = e_q * f_q;
	assign sum2_n = len_sum * len_sum;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= in_data.hand_x;
			z_s1 <= {{2{in_data.hand_z[X_W-1]}}, in_data.hand_z} - {2'b00, len_sum};

			xx_s2 <= {2'b00, xsq};
			zz_s2 <= zsq[41:0];
			ee_s2 <= ee_n;
			ff_s2 <= ff_n;
			ef_s2 <= ef_n;
			sum2_s2 <= sum2_n;
			zl_s2 <= (e_q == '0) || (f_q == '0);
			x_s2 <= x_s1;
			z_s2 <= z_s1;

			l2_s3 <= {1'b0, xx_s2} + {1'b0, zz_s2};
			ee_s3 <= ee_s2;
			ff_s3 <= ff_s2;
			ef_s3 <= ef_s2;
			sum2_s3 <= sum2_s2;
			zl_s3 <= zl_s2;
			x_s3 <= x_s2;
			z_s3 <= z_s2;

			sa_s4.c.bad <= zl_s3 || (l2_s3 == '0) || (l2_s3 > {3'b000, sum2_s3});
			sa_s4.c.x <= x_s3;
			sa_s4.c.z <= z_s3;
			sa_s4.ea <= {6'd0, ee_s3} + {6'd0, ff_s3} - {1'b0, l2_s3};
			sa_s4.sa <= {6'd0, ee_s3} - {6'd0, ff_s3} + {1'b0, l2_s3};
			sa_s4.eb <= {1'b0, ef_s3, 1'b0};
			rad_s4 <= {l2_s3[39:0], 20'd0};
		end
	end

	// distance root
	logic                          sq1_valid;
	logic [0:0][ROOT_W-1:0]        sq1_root;
	logic [$bits(side_a_t)-1:0]    sq1_side;

	tlik_sqrt #(
		.LANES (1),
		.SIDE_W($bits(side_a_t))
	) u_sqrt_len (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.up_valid(v_s4),
		.up_rad  (rad_s4),
		.up_side (sa_s4),
		.dn_valid(sq1_valid),
		.dn_root (sq1_root),
		.dn_side (sq1_side)
	);

	// arccos preparation, lane 0 elbow, lane 1 shoulder
	logic               v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	side_a_t            sa5;
	side_a_t            sa_s5;
	logic [48:0]        prod_n, prod_s5;
	logic [49:0]        b2_n;
	side_c_t            sc_s6, sc_s7, sc_s8, sc_s9, sc_s10;
	logic signed [43:0] a_s6 [2];
	logic [39:0]        b_s6 [2];
	logic signed [40:0] a_s7 [2];
	logic [39:0]        b_s7 [2];
	logic [3:0]         sh_s7 [2];
	logic signed [30:0] a_s8 [2], a_s9 [2], a_s10 [2];
	logic [29:0]        b_s8 [2];
	logic [59:0]        bb_s9 [2], aa_s9 [2];
	logic [1:0][59:0]   d_s10;

	assign sa5 = side_a_t'(sq1_side);
	assign prod_n = e_q * sq1_root[0];
	assign b2_n = {prod_s5, 1'b0} + 50'd512;

	function automatic logic signed [40:0] clamp_wide(input logic signed [43:0] a,
			input logic [39:0] b);
		logic signed [43:0] bw;
		logic signed [43:0] r;
		bw = $signed({4'd0, b});
		if (a > bw) r = bw;
		else if (a < -bw) r = -bw;
		else r = a;
		return r[40:0];
	endfunction

	function automatic logic [3:0] shift_cnt(input logic [39:0] b);
		logic [3:0] s;
		s = '0;
		for (int i = 30; i < 40; i++) begin
			if (b[i]) s = 4'(i - 29);
		end
		return s;
	endfunction

	function automatic logic [29:0] shift_b(input logic [39:0] b, input logic [3:0] sh);
		logic [39:0] t;
		t = b >> sh;
		return t[29:0];
	endfunction

	function automatic logic signed [30:0] clamp_shift(input logic signed [40:0] a,
			input logic [39:0] b, input logic [3:0] sh);
		logic signed [40:0] as_v;
		logic signed [40:0] bw;
		as_v = a >>> sh;
		bw = $signed({11'd0, shift_b(b, sh)});
		if (as_v > bw) as_v = bw;
		else if (as_v < -bw) as_v = -bw;
		return as_v[30:0];
	endfunction

	function automatic logic [29:0] abs30(input logic signed [30:0] a);
		logic signed [30:0] n;
		n = (a < 0) ? -a : a;
		return n[29:0];
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s5 <= sa5;
			prod_s5 <= prod_n;

			sc_s6 <= sa_s5.c;
			a_s6[0] <= sa_s5.ea;
			b_s6[0] <= sa_s5.eb;
			a_s6[1] <= sa_s5.sa;
			b_s6[1] <= b2_n[49:10];

			sc_s7 <= sc_s6;
			sc_s8 <= sc_s7;
			sc_s9 <= sc_s8;
			sc_s10 <= sc_s9;
			for (int l = 0; l < 2; l++) begin
				a_s7[l] <= clamp_wide(a_s6[l], b_s6[l]);
				b_s7[l] <= b_s6[l];
				sh_s7[l] <= shift_cnt(b_s6[l]);

				a_s8[l] <= clamp_shift(a_s7[l], b_s7[l], sh_s7[l]);
				b_s8[l] <= shift_b(b_s7[l], sh_s7[l]);

				bb_s9[l] <= b_s8[l] * b_s8[l];
				aa_s9[l] <= abs30(a_s8[l]) * abs30(a_s8[l]);
				a_s9[l] <= a_s8[l];

				d_s10[l] <= bb_s9[l] - aa_s9[l];
				a_s10[l] <= a_s9[l];
			end
		end
	end

	// arccos roots
	side_b_t                    sb_s10;
	logic                       sq2_valid;
	logic [1:0][ROOT_W-1:0]     sq2_root;
	logic [$bits(side_b_t)-1:0] sq2_side;
	side_b_t                    sb2;

	always_comb begin
		sb_s10.c = sc_s10;
		sb_s10.a0 = a_s10[0];
		sb_s10.a1 = a_s10[1];
	end

	tlik_sqrt #(
		.LANES (2),
		.SIDE_W($bits(side_b_t))
	) u_sqrt_acos (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.up_valid(v_s10),
		.up_rad  (d_s10),
		.up_side (sb_s10),
		.dn_valid(sq2_valid),
		.dn_root (sq2_root),
		.dn_side (sq2_side)
	);

	// three atan2 lanes: target direction, elbow, shoulder
	logic [2:0][XY_W-1:0]       cx, cy;
	logic                       cd_valid;
	logic [2:0][ANG_W-1:0]      cd_ang;
	logic [$bits(side_c_t)-1:0] cd_side;

	assign sb2 = side_b_t'(sq2_side);
	always_comb begin
		cx[0] = {{(XY_W-X_W){sb2.c.x[X_W-1]}}, sb2.c.x};
		cy[0] = {{(XY_W-22){sb2.c.z[21]}}, sb2.c.z};
		cx[1] = {sb2.a0[30], sb2.a0};
		cy[1] = {2'b00, sq2_root[0]};
		cx[2] = {sb2.a1[30], sb2.a1};
		cy[2] = {2'b00, sq2_root[1]};
	end

	tlik_cordic #(
		.LANES (3),
		.SIDE_W($bits(side_c_t)),
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.up_valid(sq2_valid),
		.up_x    (cx),
		.up_y    (cy),
		.up_side (sb2.c),
		.dn_valid(cd_valid),
		.dn_ang  (cd_ang),
		.dn_side (cd_side)
	);

	// quadrant rule, sums and output rounding
	side_c_t            sc_f;
	logic signed [29:0] t0w, q3w, q1w, t1w, shw, elw;
	out_t               out_n;
	out_t               out_q;
	logic               vout_q;

	function automatic logic signed [ANG_OUT_W-1:0] to_q12(input logic signed [29:0] v);
		logic signed [30:0] s;
		logic signed [18:0] r;
		s = {v[29], v} + 31'sd2048;
		r = 19'(s >>> 12);
		if (r > 19'sd32767) return 16'sh7fff;
		else if (r < -19'sd32768) return 16'sh8000;
		else return r[15:0];
	endfunction

	always_comb begin
		sc_f = side_c_t'(cd_side);
		t0w = {{2{cd_ang[0][ANG_W-1]}}, cd_ang[0]};
		q3w = {{2{cd_ang[1][ANG_W-1]}}, cd_ang[1]};
		q1w = {{2{cd_ang[2][ANG_W-1]}}, cd_ang[2]};
		if ((sc_f.z > 0) && (sc_f.x <= 0)) begin
			t1w = {{2{1'b0}}, ANG_THREE_HALF_PI} - t0w;
		end else begin
			t1w = -{{2{1'b0}}, ANG_HALF_PI} - t0w;
		end
		shw = t1w + q1w;
		elw = {{2{1'b0}}, ANG_PI} - q3w;
		out_n.reachable = !sc_f.bad;
		out_n.shoulder_angle = sc_f.bad ? '0 : to_q12(shw);
		out_n.elbow_angle = sc_f.bad ? '0 : to_q12(elw);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= out_n;
		end
	end

	// valid chain
	assign adv = !(vout_q && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			vout_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= sq1_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			vout_q <= cd_valid;
		end
	end

	assign out_valid = vout_q;
	assign out_data = out_q;
endmodule
`default_nettype wire

// ===== rtl/tlik_checker.sv =====
// port-level assertions for the arm solver, bound to the top level
`default_nettype none
module tlik_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input tlik_pkg::out_t out_data,
	input logic           cfg_valid,
	input logic           cfg_ready
);
	import tlik_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result beat");

	a_stall_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result beat is stalled");

	a_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.reachable |->
			out_data.shoulder_angle == '0 && out_data.elbow_angle == '0)
		else $error("unreachable beat carries nonzero angles");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write not taken");
endmodule

bind two_link_arm_inverse_kinematics tlik_checker u_tlik_checker (.*);
`default_nettype wire

// ===== test/tb_two_link_arm_inverse_kinematics.sv =====
// self-checking testbench for the two-link arm inverse kinematics solver
`default_nettype none
module tb_two_link_arm_inverse_kinematics;
	import tlik_pkg::*;

	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam longint QPI = 52707179;
	localparam longint QHALF = 26353589;
	localparam longint QTHREE = 79060768;

	class angle_board;
		out_t pending[$];
		int errors = 0;
		int checked = 0;
		int reached = 0;

		function void note(out_t v);
			pending.insert(pending.size(), v);
		endfunction

		function void check(out_t got);
			out_t want;
			if (pending.size() == 0) begin
				$error("result beat with nothing pending");
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (want.reachable) reached++;
			if (got.reachable !== want.reachable) begin
				$error("reachable expected %0d actual %0d", want.reachable, got.reachable);
				errors++;
			end
			if (got.shoulder_angle !== want.shoulder_angle) begin
				$error("shoulder_angle expected %0d actual %0d",
					want.shoulder_angle, got.shoulder_angle);
				errors++;
			end
			if (got.elbow_angle !== want.elbow_angle) begin
				$error("elbow_angle expected %0d actual %0d",
					want.elbow_angle, got.elbow_angle);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_index = CFG_UPPER;
	logic [LEN_W-1:0] cfg_data = '0;

	longint upper_len = 1024;
	longint lower_len = 1024;
	angle_board board;
	int long_gaps = 1;
	int stall_left = 0;

	two_link_arm_inverse_kinematics dut (.*);

	always #2 clk = ~clk;

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint root64(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint ang, m, ax, ay, xs, ys;
		ang = 0;
		if (x < 0) begin
			ang = (y >= 0) ? QPI : -QPI;
			x = -x;
			y = -y;
		end
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		m = ax > ay ? ax : ay;
		if (m == 0) return 0;
		while (m < (64'sd1 << 29)) begin
			m = m * 2; x = x * 2; y = y * 2;
		end
		for (int i = 0; i < STEPS && i < 32; i++) begin
			xs = shr(x, i);
			ys = shr(y, i);
			if (y >= 0) begin
				x = x + ys; y = y - xs; ang = ang + longint'(atan_tab(i));
			end else begin
				x = x - ys; y = y + xs; ang = ang - longint'(atan_tab(i));
			end
		end
		return ang;
	endfunction

	function automatic longint cosine_angle(longint a, longint b);
		if (a > b) a = b;
		if (a < -b) a = -b;
		while (b >= (64'sd1 << 30)) begin
			b = b >> 1;
			a = shr(a, 1);
		end
		if (a > b) a = b;
		if (a < -b) a = -b;
		return vector_angle(root64(b * b - a * a), a);
	endfunction

	function automatic logic signed [15:0] to_out_angle(longint v);
		longint r;
		r = shr(v + 2048, 12);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic out_t solve_arm(in_t t);
		out_t o;
		longint e, f, x, z, l2, lq, elbow_in, t0, t1, b2, sh2;
		o = '0;
		e = upper_len;
		f = lower_len;
		x = longint'(t.hand_x);
		z = longint'(t.hand_z) - (e + f);
		l2 = x * x + z * z;
		if (e == 0 || f == 0 || l2 == 0 || l2 > (e + f) * (e + f)) return o;
		lq = root64(l2 << 20);
		elbow_in = cosine_angle(e * e + f * f - l2, 2 * e * f);
		t0 = vector_angle(z, x);
		if (z <= 0) t1 = -QHALF - t0;
		else if (x <= 0) t1 = QTHREE - t0;
		else t1 = -(QHALF + t0);
		b2 = (2 * e * lq + 512) >>> 10;
		sh2 = cosine_angle(e * e - f * f + l2, b2);
		o.reachable = 1'b1;
		o.shoulder_angle = to_out_angle(t1 + sh2);
		o.elbow_angle = to_out_angle(QPI - elbow_in);
		return o;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 3) != 0) return 0;
		if (long_gaps && $urandom_range(0, 19) == 0) return $urandom_range(20, 120);
		return $urandom_range(1, 4);
	endfunction

	task automatic write_length(logic idx, logic [LEN_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_UPPER) upper_len = v;
		else lower_len = v;
		@(posedge clk);
	endtask

	task automatic send_target(logic signed [X_W-1:0] x, logic signed [X_W-1:0] z);
		in_t t;
		t.hand_x = x;
		t.hand_z = z;
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (in_stall);
		board.note(solve_arm(t));
		repeat (gap_len()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		longint reach, x, z;
		reach = upper_len + lower_len;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				x = $signed(20'($urandom));
				z = $signed(20'($urandom));
			end else begin
				x = $signed($urandom_range(0, 2 * reach)) - reach;
				z = $signed($urandom_range(0, 2 * reach)) - reach + reach;
				if (x > 524287) x = 524287;
				if (x < -524288) x = -524288;
				if (z > 524287) z = 524287;
				if (z < -524288) z = -524288;
			end
			send_target(x[X_W-1:0], z[X_W-1:0]);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) board.check(out_data);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 3) == 0)
			out_stall <= 1'b1;
		else if (long_gaps && $urandom_range(0, 99) == 0) begin
			stall_left <= $urandom_range(20, 120);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	initial begin
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_target(0, 2048);
		send_target(0, 0);
		send_target(0, 4096);
		send_target(2048, 2048);
		send_target(-2048, 2048);
		send_target(1024, 1024);
		send_target(-1024, 3072);
		send_target(1024, 3072);
		send_target(20'sh7ffff, 20'sh7ffff);
		send_target(-20'sh80000, -20'sh80000);
		send_target(20'sh7ffff, -20'sh80000);
		send_target(0, 1);
		send_target(1, 2048);
		send_target(-1, 2048);
		drain();
		write_length(CFG_UPPER, 19'h7ffff);
		write_length(CFG_LOWER, 19'h7ffff);
		send_target(0, 0);
		send_target(20'sh7ffff, 20'sh7ffff);
		send_target(-20'sh80000, 0);
		drain();
		write_length(CFG_UPPER, 1);
		write_length(CFG_LOWER, 1);
		send_target(0, 2);
		send_target(1, 2);
		send_target(0, 0);
		send_target(-1, 1);
		random_phase(150);
		drain();
		write_length(CFG_UPPER, 0);
		send_target(0, 1);
		drain();
		write_length(CFG_UPPER, 3000);
		write_length(CFG_LOWER, 1500);
		random_phase(300);
		drain();
		write_length(CFG_UPPER, 1024);
		write_length(CFG_LOWER, 1024);
		long_gaps = 0;
		random_phase(150);
		long_gaps = 1;
		random_phase(150);
		drain();
		write_length(CFG_UPPER, 19'($urandom_range(1, 100000)));
		write_length(CFG_LOWER, 19'($urandom_range(1, 100000)));
		random_phase(270);
		drain();
		$display("checked %0d solutions, %0d reachable, over six link-length settings",
			board.checked, board.reached);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
